### src/vbw_pkg.sv
// shared types and constants for the video bitstream writer
package vbw_pkg;

    // depth of the output byte queue
    localparam int unsigned OUTQ_DEPTH = 4;

    localparam logic [7:0] ESC_BYTE = 8'h03;

    // write request operations
    localparam logic [2:0] OP_RAW     = 3'd0;
    localparam logic [2:0] OP_UE      = 3'd1;
    localparam logic [2:0] OP_SE      = 3'd2;
    localparam logic [2:0] OP_LE      = 3'd3;
    localparam logic [2:0] OP_LEB     = 3'd4;
    localparam logic [2:0] OP_ALIGN   = 3'd5;
    localparam logic [2:0] OP_TRAIL   = 3'd6;
    localparam logic [2:0] OP_RESTART = 3'd7;

    // one step of the serial bit stream from the command sequencer
    typedef struct packed {
        logic bit_val;
        logic is_end;
        logic clear;
    } t_tok;

    // one completed stream byte, with a flag for an escape byte in front of it
    typedef struct packed {
        logic [7:0] data;
        logic       esc;
        logic       last;
    } t_entry;

endpackage

### src/vbw_cmd.sv
// command sequencer: turns one write request into a serial stream of code bits
module vbw_cmd
    import vbw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_operation,
    input  logic [63:0] i_value,
    input  logic [5:0]  i_count,
    input  logic [2:0]  i_pend_cnt,
    output logic        o_tok_valid,
    output t_tok        o_tok,
    input  logic        i_tok_ready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NORM,
        ST_ZEROS,
        ST_BITS,
        ST_BYTES,
        ST_END
    } t_state;

    t_state      r_state;
    logic [31:0] r_code;
    logic [5:0]  r_cnt;
    logic [5:0]  r_zeros;
    logic [63:0] r_src;
    logic [3:0]  r_bytes_left;
    logic [2:0]  r_bit;
    logic        r_leb;
    logic        r_auto;
    logic        r_clear;

    logic [31:0] w_ue_code;
    logic [31:0] w_se_code;
    logic [31:0] w_mag;
    logic [2:0]  w_trail_z;
    logic        w_leb_more;
    logic        w_cont;
    logic [7:0]  w_cur_byte;
    logic        w_code_bit;
    logic        w_tok_fire;

    // exp-golomb code words, already incremented by one, saturated to all ones
    always_comb begin
        if ((i_value[63:32] != 32'd0) || (i_value[31:0] == 32'hffff_ffff)) begin
            w_ue_code = 32'hffff_ffff;
        end else begin
            w_ue_code = i_value[31:0] + 32'd1;
        end
        w_mag = ~i_value[31:0] + 32'd1;
        if (i_value[31]) begin
            if (w_mag == 32'h8000_0000) begin
                w_se_code = 32'hffff_ffff;
            end else begin
                w_se_code = {w_mag[30:0], 1'b1};
            end
        end else if (i_value[31:0] == 32'd0) begin
            w_se_code = 32'd1;
        end else begin
            w_se_code = {i_value[30:0], 1'b0};
        end
    end

    assign w_trail_z  = ~i_pend_cnt;
    assign w_leb_more = |r_src[63:7];
    assign w_cont     = r_auto ? w_leb_more : (r_bytes_left != 4'd1);
    assign w_cur_byte = r_leb ? {w_cont, r_src[6:0]} : r_src[7:0];
    assign w_code_bit = r_code[5'(r_cnt - 6'd1)];

    always_comb begin
        o_tok_valid   = 1'b0;
        o_tok.bit_val = 1'b0;
        o_tok.is_end  = 1'b0;
        o_tok.clear   = 1'b0;
        case (r_state)
            ST_ZEROS: begin
                o_tok_valid = 1'b1;
            end
            ST_BITS: begin
                o_tok_valid   = 1'b1;
                o_tok.bit_val = w_code_bit;
            end
            ST_BYTES: begin
                o_tok_valid   = 1'b1;
                o_tok.bit_val = w_cur_byte[r_bit];
            end
            ST_END: begin
                o_tok_valid  = 1'b1;
                o_tok.is_end = 1'b1;
                o_tok.clear  = r_clear;
            end
            default: begin
                o_tok_valid = 1'b0;
            end
        endcase
    end

    assign w_tok_fire = o_tok_valid && i_tok_ready;
    assign o_stall    = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_clear <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_clear <= 1'b0;
                        r_bit   <= 3'd7;
                        r_src   <= i_value;
                        r_leb   <= 1'b0;
                        r_auto  <= 1'b0;
                        case (i_operation)
                            OP_RAW: begin
                                r_code <= i_value[31:0];
                                if (i_count > 6'd32) begin
                                    r_cnt   <= 6'd32;
                                    r_state <= ST_BITS;
                                end else begin
                                    r_cnt   <= i_count;
                                    r_state <= (i_count == 6'd0) ? ST_END : ST_BITS;
                                end
                            end
                            OP_UE: begin
                                r_code  <= w_ue_code;
                                r_cnt   <= 6'd32;
                                r_state <= ST_NORM;
                            end
                            OP_SE: begin
                                r_code  <= w_se_code;
                                r_cnt   <= 6'd32;
                                r_state <= ST_NORM;
                            end
                            OP_LE: begin
                                if (i_count > 6'd8) begin
                                    r_bytes_left <= 4'd8;
                                    r_state      <= ST_BYTES;
                                end else begin
                                    r_bytes_left <= i_count[3:0];
                                    r_state      <= (i_count == 6'd0) ? ST_END : ST_BYTES;
                                end
                            end
                            OP_LEB: begin
                                r_leb   <= 1'b1;
                                r_auto  <= (i_count == 6'd0);
                                r_state <= ST_BYTES;
                                if (i_count > 6'd10) begin
                                    r_bytes_left <= 4'd10;
                                end else begin
                                    r_bytes_left <= i_count[3:0];
                                end
                            end
                            OP_ALIGN: begin
                                r_code  <= 32'd0;
                                r_cnt   <= {3'd0, 3'd0 - i_pend_cnt};
                                r_state <= (i_pend_cnt == 3'd0) ? ST_END : ST_BITS;
                            end
                            OP_TRAIL: begin
                                // a one bit followed by the zeros up to the byte boundary
                                r_code  <= 32'd1 << w_trail_z;
                                r_cnt   <= {3'd0, w_trail_z} + 6'd1;
                                r_state <= ST_BITS;
                            end
                            OP_RESTART: begin
                                r_clear <= 1'b1;
                                r_state <= ST_END;
                            end
                            default: begin
                                r_state <= ST_END;
                            end
                        endcase
                    end
                end
                ST_NORM: begin
                    // scan down from the top bit for the leading one
                    if (w_code_bit) begin
                        r_zeros <= r_cnt - 6'd1;
                        r_state <= (r_cnt == 6'd1) ? ST_BITS : ST_ZEROS;
                    end else begin
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                ST_ZEROS: begin
                    if (w_tok_fire) begin
                        r_zeros <= r_zeros - 6'd1;
                        if (r_zeros == 6'd1) begin
                            r_state <= ST_BITS;
                        end
                    end
                end
                ST_BITS: begin
                    if (w_tok_fire) begin
                        r_cnt <= r_cnt - 6'd1;
                        if (r_cnt == 6'd1) begin
                            r_state <= ST_END;
                        end
                    end
                end
                ST_BYTES: begin
                    if (w_tok_fire) begin
                        r_bit <= r_bit - 3'd1;
                        if (r_bit == 3'd0) begin
                            r_src        <= r_leb ? (r_src >> 7) : (r_src >> 8);
                            r_bytes_left <= r_bytes_left - 4'd1;
                            if (!w_cont) begin
                                r_state <= ST_END;
                            end
                        end
                    end
                end
                ST_END: begin
                    if (w_tok_fire) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### src/vbw_pack.sv
// bit packer: assembles bytes, tracks the zero run and marks the last byte of a request
module vbw_pack
    import vbw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_prevent_en,
    input  logic       i_tok_valid,
    input  t_tok       i_tok,
    output logic       o_tok_ready,
    output logic [2:0] o_pend_cnt,
    output logic       o_push,
    output t_entry     o_entry,
    input  logic       i_full
);

    logic [6:0] r_pbits;
    logic [2:0] r_pcnt;
    logic [1:0] r_zrun;
    logic       r_held_vld;
    logic [7:0] r_held_byte;
    logic       r_held_esc;

    logic [7:0] w_byte;
    logic       w_byte_done;
    logic       w_esc;
    logic       w_fire;
    logic [1:0] w_zrun_next;

    assign o_tok_ready = !i_full;
    assign w_fire      = i_tok_valid && !i_full;
    assign w_byte      = {r_pbits, i_tok.bit_val};
    assign w_byte_done = !i_tok.is_end && (r_pcnt == 3'd7);
    assign w_esc       = i_prevent_en && (r_zrun == 2'd2) && (w_byte <= 8'd3);

    always_comb begin
        if (w_byte != 8'd0) begin
            w_zrun_next = 2'd0;
        end else if (w_esc) begin
            w_zrun_next = 2'd1;
        end else if (r_zrun == 2'd2) begin
            w_zrun_next = 2'd2;
        end else begin
            w_zrun_next = r_zrun + 2'd1;
        end
    end

    // a byte is held back until the next one or the end of the request shows whether it is last
    assign o_push        = w_fire && r_held_vld && (i_tok.is_end || w_byte_done);
    assign o_entry.data  = r_held_byte;
    assign o_entry.esc   = r_held_esc;
    assign o_entry.last  = i_tok.is_end;
    assign o_pend_cnt    = r_pcnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pbits    <= 7'd0;
            r_pcnt     <= 3'd0;
            r_zrun     <= 2'd0;
            r_held_vld <= 1'b0;
        end else if (w_fire) begin
            if (i_tok.is_end) begin
                r_held_vld <= 1'b0;
                if (i_tok.clear) begin
                    r_pbits <= 7'd0;
                    r_pcnt  <= 3'd0;
                    r_zrun  <= 2'd0;
                end
            end else if (w_byte_done) begin
                r_held_vld  <= 1'b1;
                r_held_byte <= w_byte;
                r_held_esc  <= w_esc;
                r_zrun      <= w_zrun_next;
                r_pbits     <= 7'd0;
                r_pcnt      <= 3'd0;
            end else begin
                r_pbits <= {r_pbits[5:0], i_tok.bit_val};
                r_pcnt  <= r_pcnt + 3'd1;
            end
        end
    end

endmodule

### src/vbw_outq.sv
// output byte queue with the output register that expands escape bytes
module vbw_outq
    import vbw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_entry     i_entry,
    output logic       o_full,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_byte,
    output logic       o_is_escape,
    output logic       o_last
);

    localparam int unsigned PTR_W = $clog2(OUTQ_DEPTH);
    localparam int unsigned CNT_W = $clog2(OUTQ_DEPTH + 1);

    t_entry           r_mem [OUTQ_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             r_esc_sent;
    logic             r_valid;
    logic [7:0]       r_byte;
    logic             r_is_escape;
    logic             r_last;

    t_entry w_head;
    logic   w_have;
    logic   w_load;
    logic   w_pop;

    assign w_head = r_mem[r_rptr];
    assign w_have = (r_count != CNT_W'(0));
    assign w_load = !r_valid || !i_stall;
    assign w_pop  = w_load && w_have && !(w_head.esc && !r_esc_sent);
    assign o_full = (r_count == CNT_W'(OUTQ_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr     <= '0;
            r_rptr     <= '0;
            r_count    <= '0;
            r_esc_sent <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            if (i_push) begin
                r_wptr <= PTR_W'(r_wptr + 1'b1);
            end
            if (w_pop) begin
                r_rptr <= PTR_W'(r_rptr + 1'b1);
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && w_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (w_load) begin
                r_valid <= w_have;
                if (w_have) begin
                    if (w_head.esc && !r_esc_sent) begin
                        // escape goes out first, the byte itself follows
                        r_byte      <= ESC_BYTE;
                        r_is_escape <= 1'b1;
                        r_last      <= 1'b0;
                        r_esc_sent  <= 1'b1;
                    end else begin
                        r_byte      <= w_head.data;
                        r_is_escape <= 1'b0;
                        r_last      <= w_head.last;
                        r_esc_sent  <= 1'b0;
                    end
                end
            end
        end
    end

    assign o_valid     = r_valid;
    assign o_byte      = r_byte;
    assign o_is_escape = r_is_escape;
    assign o_last      = r_last;

endmodule

### src/video_bitstream_writer.sv
// top level of the video bitstream writer
// Takes one write request at a time and packs its code bits MSB first, one bit
// per clock while the byte queue has room. Raw fields write up to 32 bits,
// little-endian up to 64, LEB128 up to 80, alignment up to 7, trailing 1 to 8
// and restart none; Exp-Golomb codes scan for their leading one before writing
// their 1 to 63 code bits. The serial bit path in the command sequencer sets
// this pace. Completed bytes go through a four-entry queue and leave at up to
// one per cycle while the receiver does not stall, escape bytes included; the
// next request is taken while earlier bytes are still queued or stalled.
module video_bitstream_writer
    import vbw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_operation,
    input  logic [63:0] i_value,
    input  logic [5:0]  i_count,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_is_escape,
    output logic        o_last
);

    logic       r_prevent_en;
    logic       w_tok_valid;
    t_tok       w_tok;
    logic       w_tok_ready;
    logic [2:0] w_pend_cnt;
    logic       w_push;
    t_entry     w_entry;
    logic       w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prevent_en <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_prevent_en <= i_cfg_wr_data;
        end
    end

    vbw_cmd u_cmd (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_operation (i_operation),
        .i_value     (i_value),
        .i_count     (i_count),
        .i_pend_cnt  (w_pend_cnt),
        .o_tok_valid (w_tok_valid),
        .o_tok       (w_tok),
        .i_tok_ready (w_tok_ready)
    );

    vbw_pack u_pack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_prevent_en (r_prevent_en),
        .i_tok_valid  (w_tok_valid),
        .i_tok        (w_tok),
        .o_tok_ready  (w_tok_ready),
        .o_pend_cnt   (w_pend_cnt),
        .o_push       (w_push),
        .o_entry      (w_entry),
        .i_full       (w_full)
    );

    vbw_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_entry     (w_entry),
        .o_full      (w_full),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_byte      (o_out_byte),
        .o_is_escape (o_is_escape),
        .o_last      (o_last)
    );

`ifndef SYNTHESIS
    // an escape byte is 0x03 and never ends a request
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_escape) |-> ((o_out_byte == ESC_BYTE) && !o_last))
        else $error("escape byte malformed");

    // the byte right after an escape is a plain byte of value 3 or less
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_escape && !i_out_stall)
            |=> (o_out_valid && !o_is_escape && (o_out_byte <= 8'd3)))
        else $error("escape not followed by its byte");

    // escapes only appear with prevention turned on
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_escape) |-> r_prevent_en)
        else $error("escape while prevention is off");
`endif

endmodule

### tb/tb_top.sv
// self-checking testbench for the video bitstream writer: command driver, byte monitor, packer model
module tb_top
    import vbw_pkg::*;
();

    // the longest request to pack serially is an exp-golomb one
    localparam int LATENCY_CYC   = 150;
    localparam int LONG_HOLD_CYC = 160;
    localparam int MAX_REPORTS   = 100;

    typedef struct packed {
        logic [2:0]  op;
        logic [63:0] val;
        logic [5:0]  cnt;
    } t_cmd;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        cfg_wr_en  = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [2:0]  in_op      = '0;
    logic [63:0] in_val     = '0;
    logic [5:0]  in_cnt     = '0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [7:0]  out_byte;
    logic        out_esc;
    logic        out_last;

    video_bitstream_writer dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_operation   (in_op),
        .i_value       (in_val),
        .i_count       (in_cnt),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_byte    (out_byte),
        .o_is_escape   (out_esc),
        .o_last        (out_last)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // packer model state
    logic [6:0] acc_bits   = '0;
    logic [2:0] acc_cnt    = '0;
    logic [1:0] zero_run_m = '0;
    logic       escape_on  = 1'b0;

    t_cmd   cmd_q[$];
    t_entry stream_q[$];

    logic   idle_on  = 1'b1;
    logic   hold_req = 1'b0;
    int     n_errors = 0;

    function automatic void emit_stream_byte(logic [7:0] b);
        t_entry e;
        if (escape_on && zero_run_m == 2'd2 && b <= 8'd3) begin
            e = '{data: ESC_BYTE, esc: 1'b1, last: 1'b0};
            stream_q.insert(stream_q.size(), e);
            zero_run_m = '0;
        end
        e = '{data: b, esc: 1'b0, last: 1'b0};
        stream_q.insert(stream_q.size(), e);
        if (b != 8'd0)
            zero_run_m = '0;
        else if (zero_run_m != 2'd2)
            zero_run_m = zero_run_m + 2'd1;
    endfunction

    // append the low n bits of v, msb first
    function automatic void shift_in(logic [63:0] v, int n);
        int i;
        for (i = n; i > 0; i--) begin
            if (acc_cnt == 3'd7) begin
                emit_stream_byte({acc_bits, v[i-1]});
                acc_bits = '0;
                acc_cnt  = '0;
            end else begin
                acc_bits = {acc_bits[5:0], v[i-1]};
                acc_cnt  = acc_cnt + 3'd1;
            end
        end
    endfunction

    function automatic int bit_len(logic [63:0] v);
        int n;
        n = 0;
        for (int i = 0; i < 64; i++)
            if (v[i]) n = i + 1;
        return n;
    endfunction

    function automatic void put_exp_golomb(logic [63:0] v);
        logic [63:0] code;
        int n;
        if (v > 64'hffff_fffe)
            v = 64'hffff_fffe;
        code = v + 64'd1;
        n = bit_len(code);
        shift_in(code, 2 * n - 1);
    endfunction

    function automatic void pack_command(t_cmd c);
        int          n;
        int          i;
        int          first;
        logic [63:0] w;
        logic [31:0] w32;
        t_entry      e;
        first = stream_q.size();
        case (c.op)
            OP_RAW: begin
                n = (c.cnt > 6'd32) ? 32 : int'(c.cnt);
                w = (n == 0) ? 64'd0 : (64'hffff_ffff >> (32 - n));
                shift_in(c.val & w, n);
            end
            OP_UE: put_exp_golomb(c.val);
            OP_SE: begin
                w32 = c.val[31:0];
                // negative values map to even code numbers, most negative one saturates
                if (w32[31])
                    w = {31'd0, 32'(-w32), 1'b0};
                else if (w32 == 32'd0)
                    w = 64'd0;
                else
                    w = {31'd0, w32, 1'b0} - 64'd1;
                put_exp_golomb(w);
            end
            OP_LE: begin
                n = (c.cnt > 6'd8) ? 8 : int'(c.cnt);
                for (i = 0; i < n; i++)
                    shift_in(64'(c.val[8*i +: 8]), 8);
            end
            OP_LEB: begin
                n = int'(c.cnt);
                if (n == 0) begin
                    n = (bit_len(c.val) + 6) / 7;
                    if (n == 0) n = 1;
                end
                if (n > 10) n = 10;
                for (i = 0; i < n; i++) begin
                    w = (c.val >> (7 * i)) & 64'h7f;
                    if (i + 1 != n) w = w | 64'h80;
                    shift_in(w, 8);
                end
            end
            OP_ALIGN: begin
                if (acc_cnt != 3'd0) shift_in(64'd0, 8 - int'(acc_cnt));
            end
            OP_TRAIL: begin
                shift_in(64'd1, 1);
                if (acc_cnt != 3'd0) shift_in(64'd0, 8 - int'(acc_cnt));
            end
            default: begin
                acc_bits   = '0;
                acc_cnt    = '0;
                zero_run_m = '0;
            end
        endcase
        if (stream_q.size() > first) begin
            e = stream_q[stream_q.size() - 1];
            e.last = 1'b1;
            stream_q[stream_q.size() - 1] = e;
        end
    endfunction

    // request driver
    t_cmd cur_cmd  = '0;
    int   gap_left = 0;
    logic offering;

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            offering = in_valid;
            if (in_valid && !in_stall) begin
                pack_command(cur_cmd);
                offering = 1'b0;
            end
            if (!offering) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (cmd_q.size() != 0) begin
                    cur_cmd  = cmd_q.pop_front();
                    offering = 1'b1;
                    if (idle_on && $urandom_range(0, 4) == 0)
                        gap_left = $urandom_range(1, 8);
                end
            end
            in_valid <= offering;
            in_op    <= cur_cmd.op;
            in_val   <= cur_cmd.val;
            in_cnt   <= cur_cmd.cnt;
        end
    end

    task automatic report_mismatch(string what, logic [7:0] want_v, logic [7:0] got_v);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want_v, got_v);
    endtask

    // byte monitor and receiver stall
    t_entry want;
    int     hold_left  = 0;
    int     stall_left = 0;

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (stream_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("%0t: byte mismatch, expected none, actual %0h", $time,
                                 out_byte);
                end else begin
                    want = stream_q.pop_front();
                    if (out_byte !== want.data)
                        report_mismatch("out_byte", want.data, out_byte);
                    if (out_esc !== want.esc)
                        report_mismatch("is_escape", 8'(want.esc), 8'(out_esc));
                    if (out_last !== want.last)
                        report_mismatch("last", 8'(want.last), 8'(out_last));
                end
            end
            if (hold_req) begin
                hold_left = LONG_HOLD_CYC;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 8) - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic add_cmd(logic [2:0] op, logic [63:0] val, logic [5:0] cnt);
        t_cmd c;
        c = '{op: op, val: val, cnt: cnt};
        cmd_q.insert(cmd_q.size(), c);
    endtask

    function automatic logic [63:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 64'($urandom_range(0, 3));
            1: return 64'($urandom_range(0, 255));
            2: return {$urandom, $urandom};
            3: return '1;
            4: return 64'd1 << $urandom_range(0, 63);
            default: return {32'($urandom), 32'h8000_0000 | 32'($urandom_range(0, 3))};
        endcase
    endfunction

    task automatic add_random(int n);
        int          added;
        int          k;
        int          j;
        logic [2:0]  op;
        logic [5:0]  cnt;
        logic [63:0] v;
        added = 0;
        while (added < n) begin
            if ($urandom_range(0, 9) < 3) begin
                // byte fields mixing zeros and small values, the pattern escapes look for
                if ($urandom_range(0, 1) == 1) begin
                    add_cmd(OP_ALIGN, rand_value(), 6'($urandom_range(0, 63)));
                    added++;
                end
                k = $urandom_range(2, 8);
                v = '0;
                for (j = 0; j < k; j++)
                    v[8*j +: 8] = ($urandom_range(0, 1) == 1) ? 8'd0 :
                        8'($urandom_range(0, ($urandom_range(0, 1) == 1) ? 3 : 255));
                add_cmd(OP_LE, v, 6'(k));
                added++;
                if ($urandom_range(0, 1) == 1) begin
                    add_cmd(OP_RAW, 64'($urandom_range(0, 3)), 6'($urandom_range(2, 10)));
                    added++;
                end
            end else begin
                op = 3'($urandom_range(0, 7));
                case (op)
                    OP_RAW: cnt = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(33, 63))
                                                             : 6'($urandom_range(0, 32));
                    OP_LE:  cnt = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(9, 63))
                                                             : 6'($urandom_range(0, 8));
                    OP_LEB: cnt = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(11, 63))
                                                             : ($urandom_range(0, 2) == 0)
                                                               ? 6'd0 : 6'($urandom_range(1, 10));
                    default: cnt = 6'($urandom_range(0, 63));
                endcase
                add_cmd(op, rand_value(), cnt);
                added++;
            end
        end
    endtask

    task automatic set_prevention(logic en);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= en;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        escape_on = en;
    endtask

    // all requests taken and every byte seen, then let trailing no-output requests finish
    task automatic wait_stream_idle();
        do @(negedge clk);
        while (cmd_q.size() != 0 || in_valid || stream_q.size() != 0);
        repeat (LATENCY_CYC) @(posedge clk);
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_prevention(1'b1);
        add_cmd(OP_RAW, 64'd0, 6'd0);
        add_cmd(OP_RAW, '1, 6'd1);
        add_cmd(OP_RAW, '1, 6'd32);
        add_cmd(OP_RAW, 64'h1234_5678_9abc_def0, 6'd63);
        add_cmd(OP_ALIGN, '1, 6'd63);
        add_cmd(OP_ALIGN, 64'd0, 6'd0);
        add_cmd(OP_UE, 64'd0, 6'd63);
        add_cmd(OP_UE, 64'hffff_fffe, 6'd0);
        add_cmd(OP_UE, '1, 6'd0);
        add_cmd(OP_SE, 64'd0, 6'd0);
        add_cmd(OP_SE, 64'd1, 6'd0);
        add_cmd(OP_SE, 64'h0000_0000_ffff_ffff, 6'd0);
        add_cmd(OP_SE, 64'hdead_beef_8000_0000, 6'd0);
        add_cmd(OP_SE, 64'h0000_0000_7fff_ffff, 6'd0);
        add_cmd(OP_TRAIL, '1, 6'd0);
        add_cmd(OP_LE, '1, 6'd8);
        add_cmd(OP_LE, 64'h0102_0304_0506_0708, 6'd40);
        add_cmd(OP_LE, '1, 6'd0);
        add_cmd(OP_LEB, 64'd0, 6'd0);
        add_cmd(OP_LEB, '1, 6'd0);
        add_cmd(OP_LEB, 64'd300, 6'd63);
        add_cmd(OP_RAW, 64'd0, 6'd16);
        add_cmd(OP_RAW, 64'd1, 6'd8);
        // restart must forget both pending bits and the zero run
        add_cmd(OP_RAW, 64'd0, 6'd16);
        add_cmd(OP_RAW, 64'd5, 6'd3);
        add_cmd(OP_RESTART, '1, 6'd63);
        add_cmd(OP_RAW, 64'd2, 6'd8);
        wait_stream_idle();

        set_prevention(1'b0);
        add_random(50);
        wait_stream_idle();

        set_prevention(1'b1);
        hold_req = 1'b1;
        add_random(60);
        wait_stream_idle();

        set_prevention(1'b0);
        add_random(40);
        wait_stream_idle();

        set_prevention(1'b1);
        idle_on = 1'b0;
        add_random(40);
        wait_stream_idle();

        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #(12 * 400000);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
